// ----- src/qtm_pkg.sv -----
// Package for the quaternion to transform unit: payload structs, widths and constants.
// No dependencies.
package qtm_pkg;

    localparam int QuatFracBits = 14;
    localparam int QuatW = 16;
    localparam int PosW = 32;
    // quotient bits before clamping: one plus a guard bit
    localparam int QW = QuatFracBits + 2;
    // squares are 31 bits unsigned at most, d up to 2^32
    localparam int DW = 33;
    // signed numerators reach 4 * 2^30
    localparam int NW = 35;
    localparam int NumEnt = 9;
    localparam logic [QW-1:0] OneQ = QW'(1) << QuatFracBits;
    localparam logic signed [QuatW-1:0] HiSat =
        (QuatFracBits >= QuatW - 1) ? QuatW'(32767) : QuatW'(1 << QuatFracBits);
    // -one fits down to 2^15; past that the 16-bit floor applies
    localparam logic signed [QuatW-1:0] LoSat =
        (QuatFracBits >= QuatW - 1) ? QuatW'(-32768) : -HiSat;
    // dividend of the rounded ratio: (2 * mag << F) + d
    localparam int XW = NW + QuatFracBits + 2;

    typedef struct packed {
        logic signed [QuatW-1:0] quat_x;
        logic signed [QuatW-1:0] quat_y;
        logic signed [QuatW-1:0] quat_z;
        logic signed [QuatW-1:0] quat_w;
        logic signed [PosW-1:0]  pos_x;
        logic signed [PosW-1:0]  pos_y;
        logic signed [PosW-1:0]  pos_z;
    } t_in;

    typedef struct packed {
        logic signed [QuatW-1:0] m00;
        logic signed [QuatW-1:0] m01;
        logic signed [QuatW-1:0] m02;
        logic signed [QuatW-1:0] m10;
        logic signed [QuatW-1:0] m11;
        logic signed [QuatW-1:0] m12;
        logic signed [QuatW-1:0] m20;
        logic signed [QuatW-1:0] m21;
        logic signed [QuatW-1:0] m22;
        logic signed [PosW-1:0]  tx;
        logic signed [PosW-1:0]  ty;
        logic signed [PosW-1:0]  tz;
    } t_out;

    // one word carried through the divider stages
    typedef struct packed {
        logic           neg;
        logic [XW-1:0]  rem;
        logic [QW-1:0]  quo;
    } t_div;

    typedef struct packed {
        logic [PosW-1:0] px;
        logic [PosW-1:0] py;
        logic [PosW-1:0] pz;
        logic            zero;
    } t_side;

endpackage

// ----- src/qtm_products.sv -----
// Products stage: ten quaternion products, then the nine signed numerators and d.
// Depends on qtm_pkg.
module qtm_products import qtm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  t_in                   i_in,
    output logic signed [NW-1:0]  o_num [NumEnt],
    output logic [DW-1:0]         o_den,
    output t_side                 o_side
);
    logic signed [2*QuatW-1:0] r_xx, r_yy, r_zz, r_ww, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_side r_side0;
    logic signed [NW-1:0] r_num [NumEnt];
    logic [DW-1:0] r_den;
    t_side r_side1;
    logic signed [NW-1:0] d_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= i_in.quat_x * i_in.quat_x;
            r_yy <= i_in.quat_y * i_in.quat_y;
            r_zz <= i_in.quat_z * i_in.quat_z;
            r_ww <= i_in.quat_w * i_in.quat_w;
            r_xy <= i_in.quat_x * i_in.quat_y;
            r_xz <= i_in.quat_x * i_in.quat_z;
            r_yz <= i_in.quat_y * i_in.quat_z;
            r_wx <= i_in.quat_w * i_in.quat_x;
            r_wy <= i_in.quat_w * i_in.quat_y;
            r_wz <= i_in.quat_w * i_in.quat_z;
            r_side0.px <= i_in.pos_x;
            r_side0.py <= i_in.pos_y;
            r_side0.pz <= i_in.pos_z;
            r_side0.zero <= (i_in.quat_x == '0) && (i_in.quat_y == '0)
                && (i_in.quat_z == '0) && (i_in.quat_w == '0);
        end
    end

    assign d_s = NW'(r_xx) + NW'(r_yy) + NW'(r_zz) + NW'(r_ww);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den    <= DW'(d_s);
            r_num[0] <= d_s - ((NW'(r_yy) + NW'(r_zz)) <<< 1);
            r_num[1] <= (NW'(r_xy) + NW'(r_wz)) <<< 1;
            r_num[2] <= (NW'(r_xz) - NW'(r_wy)) <<< 1;
            r_num[3] <= (NW'(r_xy) - NW'(r_wz)) <<< 1;
            r_num[4] <= d_s - ((NW'(r_xx) + NW'(r_zz)) <<< 1);
            r_num[5] <= (NW'(r_yz) + NW'(r_wx)) <<< 1;
            r_num[6] <= (NW'(r_xz) + NW'(r_wy)) <<< 1;
            r_num[7] <= (NW'(r_yz) - NW'(r_wx)) <<< 1;
            r_num[8] <= d_s - ((NW'(r_xx) + NW'(r_yy)) <<< 1);
            r_side1  <= r_side0;
        end
    end

    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_side = r_side1;
endmodule

// ----- src/qtm_divider.sv -----
// Pipelined restoring divider lanes: one quotient bit per stage for nine entries,
// rounding by the 2*mag*2^F + d over 2d form, then clamp. Depends on qtm_pkg.
module qtm_divider import qtm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [NW-1:0]  i_num [NumEnt],
    input  logic [DW-1:0]         i_den,
    input  t_side                 i_side,
    output t_out                  o_res
);
    // quotient is at most 2^(F+1) before clamp since |num| <= 2d; QW bits suffice
    t_div  r_st [QW+1][NumEnt];
    logic [DW-1:0] r_den [QW+1];
    t_side r_side [QW+1];
    logic signed [QuatW-1:0] m [NumEnt];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int e = 0; e < NumEnt; e++) begin
                r_st[0][e].neg <= i_num[e][NW-1];
                r_st[0][e].rem <= ((XW'(i_num[e][NW-1] ? -i_num[e] : i_num[e]))
                    << (QuatFracBits + 1)) + XW'(i_den);
                r_st[0][e].quo <= '0;
            end
            for (int s = 0; s < QW; s++) begin
                r_den[s+1]  <= r_den[s];
                r_side[s+1] <= r_side[s];
                for (int e = 0; e < NumEnt; e++) begin
                    r_st[s+1][e].neg <= r_st[s][e].neg;
                    // divisor is 2d, trial bit QW-1-s
                    if (r_st[s][e].rem >= (XW'(r_den[s]) << (QW - s))) begin
                        r_st[s+1][e].rem <= r_st[s][e].rem - (XW'(r_den[s]) << (QW - s));
                        r_st[s+1][e].quo <= r_st[s][e].quo | (QW'(1) << (QW - 1 - s));
                    end else begin
                        r_st[s+1][e].rem <= r_st[s][e].rem;
                        r_st[s+1][e].quo <= r_st[s][e].quo;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int e = 0; e < NumEnt; e++) begin
            logic [QW-1:0] q;
            logic signed [QW:0] r;
            q = (r_st[QW][e].quo > OneQ) ? OneQ : r_st[QW][e].quo;
            r = r_st[QW][e].neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
            if (r > (QW+1)'(HiSat)) begin
                m[e] = HiSat;
            end else if (r < (QW+1)'(LoSat)) begin
                m[e] = LoSat;
            end else begin
                m[e] = QuatW'(r);
            end
            if (r_side[QW].zero) begin
                m[e] = (e == 0 || e == 4 || e == 8) ? HiSat : '0;
            end
        end
        o_res.m00 = m[0];
        o_res.m01 = m[1];
        o_res.m02 = m[2];
        o_res.m10 = m[3];
        o_res.m11 = m[4];
        o_res.m12 = m[5];
        o_res.m20 = m[6];
        o_res.m21 = m[7];
        o_res.m22 = m[8];
        o_res.tx  = r_side[QW].px;
        o_res.ty  = r_side[QW].py;
        o_res.tz  = r_side[QW].pz;
    end
endmodule

// ----- src/quat_to_transform_matrix_unit.sv -----
// Top level of the quaternion to transform unit: valid pipeline, datapath, output skid.
// Depends on qtm_pkg, qtm_products, qtm_divider.
//
//  channel  | valid    | ready    | payload
//  input    | i_valid  | o_ready  | i_data (t_in)
//  output   | o_valid  | i_ready  | o_data (t_out)
//
// Stages: 2 product, QW + 1 divider and the output register; one transfer
// per cycle while the output buffer has room. The divider lanes, one
// quotient bit per stage, set the depth. Reset clears the valid bits only.
// When the output is held and both output buffer entries fill, the whole
// pipe freezes; the two-entry output buffer keeps o_ready a register.
module quat_to_transform_matrix_unit import qtm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    localparam int Depth = QW + 3;

    logic r_vld [Depth];
    logic adv;
    logic signed [NW-1:0] num [NumEnt];
    logic [DW-1:0] den;
    t_side side;
    t_out res;
    t_out r_q0, r_q1;
    logic r_v0, r_v1;

    // advance when the out buffer has room for whatever leaves the pipe
    assign adv = !r_v1;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < Depth; s++) r_vld[s] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < Depth; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    qtm_products u_prod (
        .i_clk (i_clk), .i_en (adv), .i_in (i_data),
        .o_num (num), .o_den (den), .o_side (side)
    );

    qtm_divider u_div (
        .i_clk (i_clk), .i_en (adv), .i_num (num), .i_den (den),
        .i_side (side), .o_res (res)
    );

    // two-entry output queue: r_q0 is head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            logic push, pop;
            push = adv && r_vld[Depth-1];
            pop  = r_v0 && i_ready;
            if (pop) begin
                if (r_v1) begin
                    r_q0 <= r_q1;
                    r_v1 <= push;
                    if (push) r_q1 <= res;
                end else begin
                    r_v0 <= push;
                    if (push) r_q0 <= res;
                end
            end else if (push) begin
                if (r_v0) begin
                    r_q1 <= res;
                    r_v1 <= 1'b1;
                end else begin
                    r_q0 <= res;
                    r_v0 <= 1'b1;
                end
            end
        end
    end

    assign o_valid = r_v0;
    assign o_data  = r_q0;
endmodule

// ----- src/qtm_checker.sv -----
// Port checker for the quaternion to transform unit, bound to the top level.
// Depends on qtm_pkg.
module qtm_checker import qtm_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");
    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.m00 <= HiSat && o_data.m00 >= LoSat
            && o_data.m11 <= HiSat && o_data.m22 <= HiSat)
        else $error("rotation entry out of range");
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with nothing to deliver");
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid after reset");
endmodule

bind quat_to_transform_matrix_unit qtm_checker u_chk (
    .i_clk (i_clk), .i_rst_n (i_rst_n), .o_ready (o_ready),
    .o_valid (o_valid), .i_ready (i_ready), .o_data (o_data)
);
